// File: design/wple_pkg.sv
package wple_pkg;

    // Default sizing of the top level
    localparam int TIME_WIDTH_DEF          = 32;
    localparam int PACKET_COUNT_WIDTH_DEF  = 48;
    localparam int RATIO_FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int SHARD_W     = 16;
    localparam int LEGACY_W    = 32;
    localparam int STAMP_W     = 32;
    localparam int FRAME_W     = 32;
    localparam int PKT_OUT_W   = 48;
    localparam int RATIO_OUT_W = 17;
    localparam int MIN_FR_W    = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    // Stream widths
    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 168;
    localparam int OUT_USER_W = 3;
    localparam int OUT_PAD_W  = OUT_DATA_W - 3 * RATIO_OUT_W - 2 * FRAME_W - PKT_OUT_W;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] WINDOW_TICKS_RST = 32'd1000000;
    localparam logic [MIN_FR_W-1:0]   MIN_FRAMES_RST   = 16'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES   = 1'd1;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_LEGACY = 2'd1,
        OP_RESET  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CLS_CLEAN     = 2'd0,
        CLS_RECOVERED = 2'd1,
        CLS_LOST      = 2'd2
    } t_cls;

endpackage

// File: design/wple_div.sv
module wple_div #(
    parameter int NUM_W     = 48,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [NUM_W-1:0]   i_den,
    output logic               o_done,
    output logic [FRAC_BITS:0] o_quot
);

    localparam int CNT_W = $clog2(FRAC_BITS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_den;
    logic [FRAC_BITS:0] r_quot;

    logic [NUM_W:0]     n_shift;
    logic [NUM_W:0]     n_diff;
    logic               n_bit;

    // One restoring step: shift the remainder, try to subtract the divisor
    always_comb begin
        n_shift = {r_rem, 1'b0};
        n_diff  = n_shift - {1'b0, r_den};
        n_bit   = (n_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_cnt <= '0;
                if (i_den == '0) begin
                    // Empty denominator gives zero
                    r_quot <= '0;
                    r_done <= 1'b1;
                end else if (i_num >= i_den) begin
                    // Cap the ratio at one
                    r_quot <= {1'b1, {FRAC_BITS{1'b0}}};
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_num;
                    r_quot <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= n_bit ? n_diff[NUM_W-1:0] : n_shift[NUM_W-1:0];
                r_quot <= {r_quot[FRAC_BITS-1:0], n_bit};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: design/windowed_packet_loss_estimator.sv
// Windowed packet-loss estimator.
// Input stream: tuser carries the operation (frame feedback, legacy report,
// reset, estimate query); tdata carries shard counts, legacy counts and the
// timestamp. Each accepted transaction yields exactly one output transaction:
// tuser holds the delivery class and the estimate-valid flag, tdata the three
// ratios and the window counters. Configuration (window length, minimum
// frames) is written through a plain write port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Frame feedback and legacy reports pass S_EXPIRE, S_UPDATE and S_DONE on
// their way to the output register, invalid queries S_EXPIRE, S_QUERY and
// S_DONE, resets S_EXPIRE and S_DONE. A valid query runs three divisions in
// turn on a shared radix-2 divider, one quotient bit per cycle; a ratio
// with a zero denominator or capped at one skips the bit-by-bit steps. One
// transaction is worked on at a time: tready returns as the result is
// loaded into the output register.
// A result waits in the output register while the receiver stalls; the next
// transaction can be accepted meanwhile, but its result holds until the
// register frees up. Reset clears the counters, closes the window and
// restores the register defaults (1000000 ticks, 8 frames).
module windowed_packet_loss_estimator #(
    parameter int TIME_WIDTH          = wple_pkg::TIME_WIDTH_DEF,
    parameter int PACKET_COUNT_WIDTH  = wple_pkg::PACKET_COUNT_WIDTH_DEF,
    parameter int RATIO_FRACTION_BITS = wple_pkg::RATIO_FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [wple_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wple_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // data_sent, repair_sent, data_received, repair_received, legacy_lost,
    // legacy_sent, timestamp
    input  logic [wple_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // operation
    input  logic [wple_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    // Output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // lost_pkt_ratio, unrecovered_ratio, clean_ratio, frames_seen, packets_seen,
    // unrecovered_seen, zero fill
    output logic [wple_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // delivery_class, estimate_valid
    output logic [wple_pkg::OUT_USER_W-1:0]   o_m_axis_tuser
);

    import wple_pkg::*;

    localparam int PW    = PACKET_COUNT_WIDTH;
    localparam int CMP_W = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPIRE,
        S_UPDATE,
        S_QUERY,
        S_WAIT_LOSS,
        S_WAIT_UNREC,
        S_WAIT_CLEAN,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_window_ticks;
    logic [MIN_FR_W-1:0]   r_min_frames;

    // Captured transaction
    t_op                   r_op;
    logic [SHARD_W-1:0]    r_ds;
    logic [SHARD_W-1:0]    r_rs;
    logic [SHARD_W-1:0]    r_dr;
    logic [SHARD_W-1:0]    r_rr;
    logic [LEGACY_W-1:0]   r_llost;
    logic [LEGACY_W-1:0]   r_lsent;
    logic [TIME_WIDTH-1:0] r_now;

    // Window state
    logic                  r_started;
    logic [TIME_WIDTH-1:0] r_origin;
    logic [FRAME_W-1:0]    r_frame;
    logic [FRAME_W-1:0]    r_clean;
    logic [FRAME_W-1:0]    r_unrec;
    logic [PW-1:0]         r_packet;
    logic [PW-1:0]         r_lost;

    // Pending counter increments
    logic                  r_add_frame;
    logic                  r_add_clean;
    logic                  r_add_unrec;
    logic [LEGACY_W-1:0]   r_add_pkt;
    logic [LEGACY_W-1:0]   r_add_lost;

    // Result staging
    t_cls                   r_res_cls;
    logic                   r_est_valid;
    logic [RATIO_OUT_W-1:0] r_lr;
    logic [RATIO_OUT_W-1:0] r_ur;
    logic [RATIO_OUT_W-1:0] r_cr;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    // Combinational helpers
    logic [SHARD_W:0]      n_sent;
    logic [SHARD_W:0]      n_rcv_sum;
    logic [SHARD_W:0]      n_rcv;
    logic [SHARD_W-1:0]    n_cd;
    logic [SHARD_W-1:0]    n_cr;
    logic [SHARD_W:0]      n_cd_cr;
    t_cls                  n_cls;
    logic [LEGACY_W-1:0]   n_leg_lost;
    logic [TIME_WIDTH-1:0] n_diff;
    logic                  n_expired;
    logic                  n_enough;
    logic [FRAME_W:0]      n_frame_sum;
    logic [FRAME_W:0]      n_clean_sum;
    logic [FRAME_W:0]      n_unrec_sum;
    logic [PW:0]           n_pkt_sum;
    logic [PW:0]           n_lost_sum;

    // Divider hookup
    logic                     div_start;
    logic [PW-1:0]            div_num;
    logic [PW-1:0]            div_den;
    logic                     div_done;
    logic [RATIO_FRACTION_BITS:0] div_quot;

    // Classify the frame and size the increments
    always_comb begin
        n_sent    = {1'b0, r_ds} + {1'b0, r_rs};
        n_rcv_sum = {1'b0, r_dr} + {1'b0, r_rr};
        n_rcv     = (n_rcv_sum > n_sent) ? n_sent : n_rcv_sum;
        n_cd      = (r_dr < r_ds) ? r_dr : r_ds;
        n_cr      = (r_rr < r_rs) ? r_rr : r_rs;
        n_cd_cr   = {1'b0, n_cd} + {1'b0, n_cr};
        if (r_ds == '0 || n_cd == r_ds) begin
            n_cls = CLS_CLEAN;
        end else if (n_cd_cr >= {1'b0, r_ds}) begin
            n_cls = CLS_RECOVERED;
        end else begin
            n_cls = CLS_LOST;
        end
        n_leg_lost = (r_llost < r_lsent) ? r_llost : r_lsent;
    end

    // Window expiry and estimate threshold
    always_comb begin
        n_diff    = r_now - r_origin;
        n_expired = (CMP_W'(n_diff) >= CMP_W'(r_window_ticks));
        n_enough  = (r_frame >= FRAME_W'(r_min_frames));
    end

    // Saturating counter sums
    always_comb begin
        n_frame_sum = {1'b0, r_frame} + (FRAME_W + 1)'(r_add_frame);
        n_clean_sum = {1'b0, r_clean} + (FRAME_W + 1)'(r_add_clean);
        n_unrec_sum = {1'b0, r_unrec} + (FRAME_W + 1)'(r_add_unrec);
        n_pkt_sum   = {1'b0, r_packet} + (PW + 1)'(r_add_pkt);
        n_lost_sum  = {1'b0, r_lost} + (PW + 1)'(r_add_lost);
    end

    // Feed the divider: loss, then unrecovered, then clean
    assign div_start = (r_state == S_QUERY && n_enough)
                    || (r_state == S_WAIT_LOSS && div_done)
                    || (r_state == S_WAIT_UNREC && div_done);

    always_comb begin
        case (r_state)
            S_QUERY: begin
                div_num = r_lost;
                div_den = r_packet;
            end
            S_WAIT_LOSS: begin
                div_num = PW'(r_unrec);
                div_den = PW'(r_frame);
            end
            default: begin
                div_num = PW'(r_clean);
                div_den = PW'(r_frame);
            end
        endcase
    end

    wple_div #(
        .NUM_W     (PW),
        .FRAC_BITS (RATIO_FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_TICKS_RST;
            r_min_frames   <= MIN_FRAMES_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_WINDOW_TICKS: r_window_ticks <= i_cfg_wdata;
                REG_MIN_FRAMES:   r_min_frames   <= i_cfg_wdata[MIN_FR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, window state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_origin    <= '0;
            r_frame     <= '0;
            r_clean     <= '0;
            r_unrec     <= '0;
            r_packet    <= '0;
            r_lost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once the receiver takes it, unless a new one loads
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op        <= t_op'(i_s_axis_tuser);
                        r_ds        <= i_s_axis_tdata[15:0];
                        r_rs        <= i_s_axis_tdata[31:16];
                        r_dr        <= i_s_axis_tdata[47:32];
                        r_rr        <= i_s_axis_tdata[63:48];
                        r_llost     <= i_s_axis_tdata[95:64];
                        r_lsent     <= i_s_axis_tdata[127:96];
                        r_now       <= TIME_WIDTH'(i_s_axis_tdata[159:128]);
                        r_res_cls   <= CLS_CLEAN;
                        r_est_valid <= 1'b0;
                        r_add_frame <= 1'b0;
                        r_add_clean <= 1'b0;
                        r_add_unrec <= 1'b0;
                        r_add_pkt   <= '0;
                        r_add_lost  <= '0;
                        r_state     <= S_EXPIRE;
                    end
                end
                S_EXPIRE: begin
                    if (r_op == OP_RESET) begin
                        // Clear and reopen without expiring
                        r_frame   <= '0;
                        r_clean   <= '0;
                        r_unrec   <= '0;
                        r_packet  <= '0;
                        r_lost    <= '0;
                        r_origin  <= r_now;
                        r_started <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        // Open on first use, clear when the window has run out
                        if (!r_started) begin
                            r_origin  <= r_now;
                            r_started <= 1'b1;
                        end else if (n_expired) begin
                            r_frame  <= '0;
                            r_clean  <= '0;
                            r_unrec  <= '0;
                            r_packet <= '0;
                            r_lost   <= '0;
                            r_origin <= r_now;
                        end
                        case (r_op)
                            OP_FRAME: begin
                                r_res_cls   <= n_cls;
                                r_add_frame <= 1'b1;
                                r_add_clean <= (n_cls == CLS_CLEAN);
                                r_add_unrec <= (n_cls == CLS_LOST);
                                r_add_pkt   <= LEGACY_W'(n_sent);
                                r_add_lost  <= LEGACY_W'(n_sent - n_rcv);
                                r_state     <= S_UPDATE;
                            end
                            OP_LEGACY: begin
                                r_add_pkt  <= r_lsent;
                                r_add_lost <= n_leg_lost;
                                r_state    <= S_UPDATE;
                            end
                            default: r_state <= S_QUERY;
                        endcase
                    end
                end
                S_UPDATE: begin
                    // Add with saturation at the counter maximum
                    r_frame  <= n_frame_sum[FRAME_W] ? '1 : n_frame_sum[FRAME_W-1:0];
                    r_clean  <= n_clean_sum[FRAME_W] ? '1 : n_clean_sum[FRAME_W-1:0];
                    r_unrec  <= n_unrec_sum[FRAME_W] ? '1 : n_unrec_sum[FRAME_W-1:0];
                    r_packet <= n_pkt_sum[PW] ? '1 : n_pkt_sum[PW-1:0];
                    r_lost   <= n_lost_sum[PW] ? '1 : n_lost_sum[PW-1:0];
                    r_state  <= S_DONE;
                end
                S_QUERY: begin
                    if (n_enough) begin
                        r_est_valid <= 1'b1;
                        r_state     <= S_WAIT_LOSS;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_WAIT_LOSS: begin
                    if (div_done) begin
                        r_lr    <= RATIO_OUT_W'(div_quot);
                        r_state <= S_WAIT_UNREC;
                    end
                end
                S_WAIT_UNREC: begin
                    if (div_done) begin
                        r_ur    <= RATIO_OUT_W'(div_quot);
                        r_state <= S_WAIT_CLEAN;
                    end
                end
                S_WAIT_CLEAN: begin
                    if (div_done) begin
                        r_cr    <= RATIO_OUT_W'(div_quot);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the result over once the output register is free
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= {r_est_valid, r_res_cls};
                        if (r_est_valid) begin
                            r_out_data <= {{OUT_PAD_W{1'b0}}, r_unrec,
                                           PKT_OUT_W'(r_packet), r_frame,
                                           r_cr, r_ur, r_lr};
                        end else begin
                            r_out_data <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
